// ===== rtl/swf_tcv_pkg.sv =====
`timescale 1ns / 1ps
package swf_tcv_pkg;

    localparam int REGION_BITS_DEF = 29;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 29;
    localparam int TOL_W           = 8;
    localparam int LIMIT_W         = 20;
    localparam int CFG_DATA_W      = 20;
    localparam int CFG_IDX_W       = 1;
    localparam int HDR_LEN_W       = 32;
    localparam int HDR_BYTES       = 6;
    localparam int DECL_BYTES      = 4;

    localparam int MIN_REGION   = 9;
    localparam int MIN_DECL_LEN = 8;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd64;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_S = 8'h53;

    localparam logic [5:0] TL_LONG = 6'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE = 1'b0,
        CFG_TAG_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_SIGNATURE = 3'd1,
        RSN_DECL_LEN  = 3'd2,
        RSN_REGION    = 3'd3,
        RSN_OVERRUN   = 3'd4,
        RSN_MISMATCH  = 3'd5,
        RSN_TAG_LIMIT = 3'd6
    } t_reason;

    typedef struct packed {
        logic [TOL_W-1:0]   tolerance;
        logic [LIMIT_W-1:0] tag_limit;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic             is_valid;
        t_reason          reason;
        logic [LEN_W-1:0] file_length;
    } t_verdict;

endpackage

// ===== rtl/swf_tag_chain_validator.sv =====
`timescale 1ns / 1ps
// SWF tag chain validator, uncompressed files only.
// Input channel: one byte of a candidate file per beat (i_in_valid / o_in_stall).
// i_start_of_candidate marks byte 0 and samples i_region_length, the bytes
// available to the candidate. A start during a candidate abandons it.
// Output channel: one verdict per candidate (o_out_valid / i_out_stall) with
// o_is_valid, o_fail_reason and o_file_length (bytes through the End tag).
// Bytes after a verdict and before the next start are taken and dropped.
// Throughput: one byte per cycle while the receiver does not stall. Each byte goes
// through one input register, one pass of the parser logic and, if it decides the
// candidate, the output register, which then holds its verdict.
// When the receiver stalls, the held verdict blocks the parser stage; at most
// one more byte is taken into the input register, then o_in_stall stays high
// until the verdict is taken.
// Configuration: i_cfg_we writes register i_cfg_index (0 length tolerance,
// 1 tag limit) from i_cfg_data; write only while no candidate is in flight.
// Reset (synchronous, active low) empties both registers, idles the parser
// and restores tolerance 64 and tag limit 100000.
module swf_tag_chain_validator
    import swf_tcv_pkg::*;
#(
    parameter int REGION_BITS = REGION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic                  i_start_of_candidate,
    input  logic [LEN_W-1:0]      i_region_length,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_is_valid,
    output logic [2:0]            o_fail_reason,
    output logic [LEN_W-1:0]      o_file_length,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic [LEN_W-1:0]  r_in_region;

    logic              r_out_valid;
    logic              r_out_is_valid;
    t_reason           r_out_reason;
    logic [LEN_W-1:0]  r_out_len;

    logic              adv, fire, in_take;
    t_cfg              cfg;
    t_verdict          verdict;

    swf_tcv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swf_tcv_parser #(
        .REGION_BITS (REGION_BITS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_byte_value    (r_in_byte),
        .i_start         (r_in_start),
        .i_region_length (r_in_region),
        .i_cfg           (cfg),
        .o_verdict       (verdict)
    );

    // parser stage moves when the output register is free or being emptied
    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) r_out_valid <= fire && verdict.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte   <= i_byte_value;
            r_in_start  <= i_start_of_candidate;
            r_in_region <= i_region_length;
        end
        if (fire && verdict.hit) begin
            r_out_is_valid <= verdict.is_valid;
            r_out_reason   <= verdict.reason;
            r_out_len      <= verdict.file_length;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_is_valid    = r_out_is_valid;
    assign o_fail_reason = r_out_reason;
    assign o_file_length = r_out_len;

    a_fail_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_valid |-> o_fail_reason != RSN_OK && o_file_length == '0)
        else $error("failed verdict with ok reason or nonzero length");

    a_pass_reason_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_valid |-> o_fail_reason == RSN_OK)
        else $error("valid verdict with a fail reason");

    a_hold_in_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("input stage consumed while the verdict was stalled");

endmodule

// ===== rtl/swf_tcv_cfg.sv =====
`timescale 1ns / 1ps
module swf_tcv_cfg
    import swf_tcv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [TOL_W-1:0]   r_tolerance;
    logic [LIMIT_W-1:0] r_tag_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
            r_tag_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_W-1:0];
                CFG_TAG_LIMIT: r_tag_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.tolerance = r_tolerance;
    assign o_cfg.tag_limit = r_tag_limit;

endmodule

// ===== rtl/swf_tcv_parser.sv =====
`timescale 1ns / 1ps
module swf_tcv_parser
    import swf_tcv_pkg::*;
#(
    parameter int REGION_BITS = REGION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic              i_start,
    input  logic [LEN_W-1:0]  i_region_length,
    input  t_cfg              i_cfg,
    output t_verdict          o_verdict
);

    localparam int PW = REGION_BITS + 1;
    localparam int SW = ((PW > HDR_LEN_W) ? PW : HDR_LEN_W) + 1;
    localparam int XW = (REGION_BITS > LEN_W) ? REGION_BITS : LEN_W;
    localparam logic [XW-1:0] CAP = XW'(1) << (REGION_BITS - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIG,
        PH_VER,
        PH_LEN,
        PH_RECT,
        PH_RSKIP,
        PH_HDR,
        PH_BODY
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [PW-1:0]                r_pos, n_pos;
    logic [REGION_BITS-1:0]       r_region, n_region;
    logic [DECL_BYTES-1:0][7:0]   r_dl, n_dl;
    logic [HDR_BYTES-1:0][7:0]    r_hdr, n_hdr;
    logic [2:0]                   r_hdr_cnt, n_hdr_cnt;
    logic [PW-1:0]                r_skip, n_skip;
    logic [LIMIT_W-1:0]           r_tags, n_tags;

    // state as seen by this byte (a start byte restarts the candidate)
    logic [XW-1:0]                reg_ext, reg_clamp;
    logic [REGION_BITS-1:0]       start_region, e_region;
    t_phase                       e_phase;
    logic [PW-1:0]                e_pos, pos_inc;
    logic [DECL_BYTES-1:0][7:0]   e_dl, dl_new;
    logic [HDR_BYTES-1:0][7:0]    e_hdr, hdr_new;
    logic [2:0]                   e_cnt, cnt_new;
    logic [LIMIT_W-1:0]           e_tags;

    logic [SW-1:0]                s_region, s_pos, s_end, s_dl, s_tol;
    logic [7:0]                   want;
    logic [7:0]                   rect_sum;
    logic [4:0]                   rect_skip;
    logic [5:0]                   tl_short;
    logic [HDR_LEN_W-1:0]         tl_long, tl_fin;
    logic                         code_zero;
    logic                         tiny, bnd_short, tag_full, first_hdr;
    logic                         dl_bad, long_short, body_over, mismatch;

    logic                         v_hit, do_fin, do_bnd;
    t_reason                      v_reason;

    assign reg_ext      = XW'(i_region_length);
    assign reg_clamp    = (reg_ext > CAP) ? CAP : reg_ext;
    assign start_region = REGION_BITS'(reg_clamp);
    assign tiny         = start_region < REGION_BITS'(MIN_REGION);

    assign e_region = i_start ? start_region : r_region;
    assign e_phase  = i_start ? PH_SIG : r_phase;
    assign e_pos    = i_start ? '0 : r_pos;
    assign e_dl     = i_start ? '0 : r_dl;
    assign e_hdr    = i_start ? '0 : r_hdr;
    assign e_cnt    = i_start ? '0 : r_hdr_cnt;
    assign e_tags   = i_start ? '0 : r_tags;
    assign pos_inc  = e_pos + PW'(1);
    assign cnt_new  = e_cnt + 3'd1;

    always_comb begin
        dl_new = e_dl;
        for (int i = 0; i < DECL_BYTES; i++) begin
            if (e_pos[1:0] == 2'(i)) dl_new[i] = i_byte_value;
        end
        hdr_new = e_hdr;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (e_cnt == 3'(i)) hdr_new[i] = i_byte_value;
        end
    end

    always_comb begin
        case (e_pos[1:0])
            2'd0:    want = CH_F;
            2'd1:    want = CH_W;
            default: want = CH_S;
        endcase
    end

    // rect bytes: ceil(nbits * 4 / 8)
    assign rect_sum  = {1'b0, i_byte_value[7:3], 2'b00} + 8'd7;
    assign rect_skip = rect_sum[7:3];

    assign tl_short  = hdr_new[0][5:0];
    assign tl_long   = hdr_new[5:2];
    assign tl_fin    = (cnt_new == 3'(HDR_BYTES)) ? tl_long : HDR_LEN_W'(tl_short);
    assign code_zero = ({hdr_new[1], hdr_new[0][7:6]} == 10'd0);

    assign s_region = SW'(e_region);
    assign s_pos    = SW'(e_pos);
    assign s_end    = SW'(pos_inc);
    assign s_dl     = SW'(dl_new);
    assign s_tol    = SW'(i_cfg.tolerance);

    assign bnd_short  = (s_pos + SW'(3)) > s_region;
    assign tag_full   = e_tags >= i_cfg.tag_limit;
    assign first_hdr  = (e_phase == PH_RECT) || (e_phase == PH_RSKIP);
    assign dl_bad     = (dl_new < HDR_LEN_W'(MIN_DECL_LEN)) || (s_dl > s_region + SW'(1));
    assign long_short = (s_pos + SW'(5)) > s_region;
    assign body_over  = (s_end + SW'(tl_fin)) > s_region;
    assign mismatch   = (s_end > SW'(e_dl) + s_tol) || (SW'(e_dl) > s_end + s_tol);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_region  = r_region;
        n_dl      = r_dl;
        n_hdr     = r_hdr;
        n_hdr_cnt = r_hdr_cnt;
        n_skip    = r_skip;
        n_tags    = r_tags;
        v_hit     = 1'b0;
        v_reason  = RSN_OK;
        do_fin    = 1'b0;
        do_bnd    = 1'b0;
        if (i_fire) begin
            if (i_start) begin
                n_phase   = PH_SIG;
                n_pos     = '0;
                n_region  = start_region;
                n_dl      = '0;
                n_hdr     = '0;
                n_hdr_cnt = '0;
                n_tags    = '0;
            end
            if (i_start && tiny) begin
                v_hit    = 1'b1;
                v_reason = RSN_REGION;
            end else if (e_phase != PH_IDLE) begin
                n_pos = pos_inc;
                case (e_phase)
                    PH_SIG: begin
                        if (i_byte_value != want) begin
                            v_hit    = 1'b1;
                            v_reason = RSN_SIGNATURE;
                        end else if (e_pos[1:0] == 2'd2) begin
                            n_phase = PH_VER;
                        end
                    end
                    PH_VER: n_phase = PH_LEN;
                    PH_LEN: begin
                        n_dl = dl_new;
                        if (e_pos[1:0] == 2'd3) begin
                            if (dl_bad) begin
                                v_hit    = 1'b1;
                                v_reason = RSN_DECL_LEN;
                            end else begin
                                n_phase = PH_RECT;
                            end
                        end
                    end
                    PH_RECT: begin
                        if (rect_skip == 5'd0) begin
                            do_bnd = 1'b1;
                        end else begin
                            n_skip  = PW'(rect_skip);
                            n_phase = PH_RSKIP;
                        end
                    end
                    PH_RSKIP, PH_BODY: begin
                        n_skip = r_skip - PW'(1);
                        if (r_skip == PW'(1)) do_bnd = 1'b1;
                    end
                    PH_HDR: begin
                        n_hdr     = hdr_new;
                        n_hdr_cnt = cnt_new;
                        if (cnt_new == 3'd2) begin
                            if (tl_short == TL_LONG) begin
                                if (long_short) begin
                                    v_hit    = 1'b1;
                                    v_reason = RSN_OVERRUN;
                                end
                            end else begin
                                do_fin = 1'b1;
                            end
                        end else if (cnt_new == 3'(HDR_BYTES)) begin
                            do_fin = 1'b1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
                if (do_fin) begin
                    if (code_zero && tl_fin == '0) begin
                        // end tag
                        v_hit    = 1'b1;
                        v_reason = mismatch ? RSN_MISMATCH : RSN_OK;
                    end else if (body_over) begin
                        v_hit    = 1'b1;
                        v_reason = RSN_OVERRUN;
                    end else if (tl_fin == '0) begin
                        do_bnd = 1'b1;
                    end else begin
                        // body fits in the region, so it fits the counter
                        n_skip  = PW'(tl_fin);
                        n_phase = PH_BODY;
                    end
                end
                if (do_bnd) begin
                    if (bnd_short) begin
                        v_hit    = 1'b1;
                        v_reason = first_hdr ? RSN_REGION : RSN_OVERRUN;
                    end else if (tag_full) begin
                        v_hit    = 1'b1;
                        v_reason = RSN_TAG_LIMIT;
                    end else begin
                        n_tags    = e_tags + LIMIT_W'(1);
                        n_phase   = PH_HDR;
                        n_hdr_cnt = '0;
                        n_hdr     = '0;
                    end
                end
            end
            if (v_hit) n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_region  <= '0;
            r_dl      <= '0;
            r_hdr     <= '0;
            r_hdr_cnt <= '0;
            r_skip    <= '0;
            r_tags    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_region  <= n_region;
            r_dl      <= n_dl;
            r_hdr     <= n_hdr;
            r_hdr_cnt <= n_hdr_cnt;
            r_skip    <= n_skip;
            r_tags    <= n_tags;
        end
    end

    assign o_verdict.hit         = v_hit;
    assign o_verdict.is_valid    = (v_reason == RSN_OK);
    assign o_verdict.reason      = v_reason;
    assign o_verdict.file_length = (v_reason == RSN_OK) ? LEN_W'(pos_inc) : '0;

    a_idle_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && v_hit |=> r_phase == PH_IDLE)
        else $error("parser kept running after a verdict");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HDR |-> r_hdr_cnt < 3'(HDR_BYTES))
        else $error("tag header byte count out of range");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY || r_phase == PH_RSKIP) |-> r_skip != '0)
        else $error("skip phase with nothing left to skip");

endmodule
